/* sv/lbtr_pkg.sv */
// shared types and codes for the lsh bucket table
package lbtr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_LOAD   = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_APPENDED    = 3'd0,
    ST_REPLACED    = 3'd1,
    ST_SAMPLED_OUT = 3'd2,
    ST_DROPPED     = 3'd3,
    ST_BAD_ADDR    = 3'd4,
    ST_QUERY_LABEL = 3'd5,
    ST_QUERY_EMPTY = 3'd6,
    ST_DONE        = 3'd7
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLES    = 2'd0,
    CFG_RANGE     = 2'd1,
    CFG_RESERVOIR = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR_RD, S_CLR_WR, S_META, S_RAND,
    S_MOD_R, S_Q_RD, S_Q_OUT, S_EMIT, S_LOAD
  } fsm_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] label;
    logic [15:0] hash_value;
    logic [2:0]  table_number;
    logic [7:0]  rand_slot;
    logic [31:0] rand_word;
    logic        end_of_batch;
  } in_item_t;

  typedef struct packed {
    logic [31:0] label_out;
    logic [2:0]  status;
    logic [4:0]  slot_used;
    logic        last;
    logic        batch_done;
  } out_item_t;

endpackage

/* sv/lbtr_stream_if.sv */
// valid/ready channel carrying one item
interface lbtr_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* sv/lbtr_mod.sv */
// bit-serial remainder unit, one dividend bit per cycle
module lbtr_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [32:0] remainder
);
  logic [31:0] shreg;
  logic [32:0] div_q;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;

  assign trial = {remainder, shreg[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      shreg     <= dividend;
      div_q     <= divisor;
    end else if (busy) begin
      shreg <= {shreg[30:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        remainder <= 33'(trial - {1'b0, div_q});
      end else begin
        remainder <= trial[32:0];
      end
    end
  end
endmodule

/* sv/lsh_bucket_table_reservoir.sv */
// lsh bucket table: insert, reservoir insert and query, one S_Q_RD/S_Q_OUT pair per label
// reservoir path runs one serial remainder for the random pick
// load subtracts RAND_DEPTH from the slot until it lies below the table depth
// clear sweeps the bucket metadata memory, a read and a write per bucket
// after synchronous reset a sweep over every bucket zeroes fill and
// trial counts before the first item is taken
module lsh_bucket_table_reservoir #(
  parameter int MAX_TABLES = 8,
  parameter int MAX_RANGE  = 64,
  parameter int BUCKET_CAP = 32,
  parameter int RAND_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  lbtr_stream_if.sink                     items_in,
  lbtr_stream_if.source                   results_out,
  input  logic                            write_enable,
  input  logic [lbtr_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [lbtr_pkg::CFG_DATA_W-1:0] write_data
);
  import lbtr_pkg::*;

  localparam int NB  = MAX_TABLES * MAX_RANGE;
  localparam int BW  = $clog2(NB);
  localparam int SAW = $clog2(NB * BUCKET_CAP);
  localparam int SW  = (BUCKET_CAP > 1) ? $clog2(BUCKET_CAP) : 1;
  localparam int FW  = $clog2(BUCKET_CAP + 1);
  localparam int RW  = (RAND_DEPTH > 1) ? $clog2(RAND_DEPTH) : 1;
  localparam int MW  = 32 + FW;

  // configuration
  logic [3:0] tables_in_use;
  logic [6:0] range_in_use;
  logic [5:0] reservoir_limit;
  logic [31:0] tables_sat, range_sat, res_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      tables_in_use   <= 4'd8;
      range_in_use    <= 7'd64;
      reservoir_limit <= 6'd0;
    end else if (write_enable) begin
      case (reg_index)
        CFG_TABLES:    tables_in_use   <= write_data[3:0];
        CFG_RANGE:     range_in_use    <= write_data[6:0];
        CFG_RESERVOIR: reservoir_limit <= write_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tables_sat = 32'(tables_in_use);
    if (tables_sat < 32'd1) tables_sat = 32'd1;
    if (tables_sat > 32'(MAX_TABLES)) tables_sat = 32'(MAX_TABLES);
    range_sat = 32'(range_in_use);
    if (range_sat < 32'd1) range_sat = 32'd1;
    if (range_sat > 32'(MAX_RANGE)) range_sat = 32'(MAX_RANGE);
    res_sat = 32'(reservoir_limit);
    if (res_sat > 32'(BUCKET_CAP)) res_sat = 32'(BUCKET_CAP);
  end

  // item registers
  fsm_t          state, state_next;
  logic [1:0]    cmd_q;
  logic [31:0]   label_q, rword_q, n_q, total_trials;
  logic [RW-1:0] tidx;
  logic [7:0]    lslot;
  logic          eob_q;
  logic [BW-1:0] bkt, cnt;
  logic [FW-1:0] fill_q;
  logic [SW-1:0] qi;
  out_item_t     pend, out_q, out_next;
  logic          out_valid, out_load, slot_free;

  // memories
  logic [31:0]   store_mem [NB*BUCKET_CAP];
  logic [MW-1:0] meta_mem  [NB];
  logic [31:0]   rand_mem  [RAND_DEPTH];

  logic           store_we, store_re;
  logic [SAW-1:0] store_waddr, store_raddr;
  logic [31:0]    store_q;
  logic           meta_we, meta_re;
  logic [BW-1:0]  meta_waddr, meta_raddr;
  logic [MW-1:0]  meta_wdata, meta_q;
  logic           rand_we, rand_re;
  logic [RW-1:0]  rand_addr;
  logic [31:0]    rand_q;

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_waddr] <= label_q;
    if (store_re) store_q <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (meta_re) meta_q <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (rand_we) rand_mem[rand_addr] <= rword_q;
    if (rand_re) rand_q <= rand_mem[rand_addr];
  end

  // remainder unit
  logic        mod_start, mod_done;
  logic [31:0] mod_dividend;
  logic [32:0] mod_divisor, mod_rem;

  lbtr_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  logic [FW-1:0] fill_rd;
  logic [31:0]   count_rd;
  logic          bad_addr;
  logic [31:0]   bkt_calc;
  logic          reservoir_hit, bucket_full, q_last, pick_hit, lslot_big;

  assign fill_rd  = meta_q[FW-1:0];
  assign count_rd = meta_q[MW-1:FW];
  assign bad_addr = (32'(items_in.data.hash_value) >= range_sat) ||
                    (32'(items_in.data.table_number) >= tables_sat);
  assign bkt_calc = 32'(items_in.data.table_number) * range_sat +
                    32'(items_in.data.hash_value);
  assign reservoir_hit = (res_sat != 32'd0) && (32'(fill_rd) == res_sat);
  assign bucket_full   = 32'(fill_rd) >= 32'(BUCKET_CAP);
  assign q_last        = (32'(qi) + 32'd1) == 32'(fill_q);
  assign pick_hit      = mod_rem < 33'(res_sat);
  assign slot_free     = !out_valid || results_out.ready;
  // load slot is brought below the table depth by repeated subtraction
  assign lslot_big     = 32'(lslot) >= 32'(RAND_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   if (cnt == BW'(NB - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (items_in.valid) begin
          unique case (command_t'(items_in.data.command))
            CMD_CLEAR: state_next = S_CLR_RD;
            CMD_LOAD:  state_next = S_LOAD;
            CMD_INSERT, CMD_QUERY: state_next = bad_addr ? S_EMIT : S_META;
          endcase
        end
      end
      S_CLR_RD: state_next = S_CLR_WR;
      S_CLR_WR: state_next = (cnt == BW'(NB - 1)) ? S_EMIT : S_CLR_RD;
      S_META: begin
        if (cmd_q == CMD_QUERY) begin
          state_next = (fill_rd == '0) ? S_EMIT : S_Q_RD;
        end else begin
          state_next = reservoir_hit ? S_RAND : S_EMIT;
        end
      end
      S_RAND:   state_next = S_MOD_R;
      S_MOD_R:  if (mod_done) state_next = S_EMIT;
      S_Q_RD:   state_next = S_Q_OUT;
      S_Q_OUT:  if (slot_free) state_next = q_last ? S_IDLE : S_Q_RD;
      S_EMIT:   if (slot_free) state_next = S_IDLE;
      S_LOAD:   if (!lslot_big) state_next = S_EMIT;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory, unit and port controls
  always_comb begin
    items_in.ready = 1'b0;
    store_we     = 1'b0;
    store_re     = 1'b0;
    store_waddr  = SAW'(bkt) * SAW'(BUCKET_CAP) + SAW'(fill_q);
    store_raddr  = SAW'(bkt) * SAW'(BUCKET_CAP) + SAW'(qi);
    meta_we      = 1'b0;
    meta_re      = 1'b0;
    meta_waddr   = bkt;
    meta_raddr   = BW'(bkt_calc);
    meta_wdata   = {count_rd, fill_rd};
    rand_we      = 1'b0;
    rand_re      = 1'b0;
    rand_addr    = tidx;
    mod_start    = 1'b0;
    mod_dividend = rand_q;
    mod_divisor  = {1'b0, n_q} + 33'd1;
    out_load     = 1'b0;
    out_next     = pend;
    unique case (state)
      S_INIT: begin
        meta_we    = 1'b1;
        meta_waddr = cnt;
        meta_wdata = '0;
      end
      S_IDLE: begin
        items_in.ready = 1'b1;
        meta_re        = items_in.valid;
      end
      S_CLR_RD: begin
        meta_re    = 1'b1;
        meta_raddr = cnt;
      end
      S_CLR_WR: begin
        meta_we    = 1'b1;
        meta_waddr = cnt;
        meta_wdata = {count_rd, FW'(0)};
      end
      S_META: begin
        if (cmd_q == CMD_INSERT) begin
          if (reservoir_hit) begin
            meta_we    = 1'b1;
            meta_wdata = {count_rd + 32'd1, fill_rd};
            rand_re    = 1'b1;
          end else if (!bucket_full) begin
            meta_we     = 1'b1;
            meta_wdata  = {count_rd, fill_rd + FW'(1)};
            store_we    = 1'b1;
            store_waddr = SAW'(bkt) * SAW'(BUCKET_CAP) + SAW'(fill_rd);
          end
        end
      end
      S_RAND:   mod_start = 1'b1;
      S_MOD_R: begin
        if (mod_done && pick_hit) begin
          store_we    = 1'b1;
          store_waddr = SAW'(bkt) * SAW'(BUCKET_CAP) + SAW'(mod_rem[SW-1:0]);
        end
      end
      S_Q_RD:   store_re = 1'b1;
      S_Q_OUT: begin
        out_load = slot_free;
        out_next = '{label_out: store_q, status: ST_QUERY_LABEL,
                     slot_used: 5'(qi), last: q_last, batch_done: 1'b0};
      end
      S_EMIT:   out_load = slot_free;
      S_LOAD: begin
        rand_we   = !lslot_big;
        rand_addr = RW'(lslot);
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      total_trials <= '0;
      tidx         <= '0;
    end else begin
      unique case (state)
        S_INIT:   cnt <= (cnt == BW'(NB - 1)) ? '0 : cnt + BW'(1);
        S_CLR_WR: cnt <= (cnt == BW'(NB - 1)) ? '0 : cnt + BW'(1);
        S_META: begin
          if (cmd_q == CMD_INSERT && reservoir_hit) begin
            total_trials <= total_trials + 32'd1;
            // table index follows the trial count modulo the table depth
            tidx <= (total_trials == '1 || tidx == RW'(RAND_DEPTH - 1)) ? '0 :
                    tidx + RW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (items_in.valid) begin
          cmd_q   <= items_in.data.command;
          label_q <= items_in.data.label;
          eob_q   <= items_in.data.end_of_batch;
          rword_q <= items_in.data.rand_word;
          lslot   <= items_in.data.rand_slot;
          bkt     <= BW'(bkt_calc);
          if (items_in.data.command == CMD_INSERT) begin
            pend <= '{label_out: items_in.data.label, status: ST_BAD_ADDR, slot_used: 5'd0,
                      last: 1'b1, batch_done: items_in.data.end_of_batch};
          end else begin
            pend <= '{label_out: 32'd0, status: ST_BAD_ADDR, slot_used: 5'd0,
                      last: 1'b1, batch_done: 1'b0};
          end
        end
      end
      S_CLR_WR: begin
        pend <= '{label_out: 32'd0, status: ST_DONE, slot_used: 5'd0,
                  last: 1'b1, batch_done: 1'b0};
      end
      S_LOAD: begin
        pend <= '{label_out: 32'd0, status: ST_DONE, slot_used: 5'd0,
                  last: 1'b1, batch_done: 1'b0};
        if (lslot_big) lslot <= 8'(32'(lslot) - 32'(RAND_DEPTH));
      end
      S_META: begin
        fill_q <= fill_rd;
        n_q    <= count_rd;
        qi     <= '0;
        if (cmd_q == CMD_QUERY) begin
          pend <= '{label_out: 32'd0, status: ST_QUERY_EMPTY, slot_used: 5'd0,
                    last: 1'b1, batch_done: 1'b0};
        end else if (bucket_full) begin
          pend <= '{label_out: label_q, status: ST_DROPPED, slot_used: 5'd0,
                    last: 1'b1, batch_done: eob_q};
        end else begin
          pend <= '{label_out: label_q, status: ST_APPENDED, slot_used: 5'(fill_rd),
                    last: 1'b1, batch_done: eob_q};
        end
      end
      S_MOD_R: begin
        if (pick_hit) begin
          pend <= '{label_out: label_q, status: ST_REPLACED, slot_used: 5'(mod_rem),
                    last: 1'b1, batch_done: eob_q};
        end else begin
          pend <= '{label_out: label_q, status: ST_SAMPLED_OUT, slot_used: 5'd0,
                    last: 1'b1, batch_done: eob_q};
        end
      end
      S_Q_OUT:  if (slot_free) qi <= qi + SW'(1);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_q <= out_next;
  end

  assign results_out.valid = out_valid;
  assign results_out.data  = out_q;
endmodule

/* bench/tb.sv */
// testbench for the lsh bucket table: scoreboard class, stimulus tasks and checks
module tb;
  import lbtr_pkg::*;

  localparam int NUM_BUCKETS = 512;
  localparam int CAP         = 32;
  localparam int WORDS       = 256;
  localparam int LIMIT       = 3000000;
  localparam int SETTLE      = 200;

  class bucket_scoreboard;
    bit [31:0] store [NUM_BUCKETS][CAP];
    bit [5:0]  fill [NUM_BUCKETS];
    bit [31:0] trials [NUM_BUCKETS];
    bit [31:0] total_trials;
    bit [31:0] words [WORDS];
    bit        loaded [WORDS];
    bit [3:0]  tables_reg;
    bit [6:0]  range_reg;
    bit [5:0]  res_reg;
    out_item_t pending_results[$];
    int        mismatches;
    int        results_seen;
    int        status_seen [8];

    function new();
      tables_reg = 8;
      range_reg = 64;
      res_reg = 0;
      total_trials = 0;
      foreach (fill[i]) begin
        fill[i] = 0;
        trials[i] = 0;
      end
      foreach (loaded[i]) loaded[i] = 0;
    endfunction

    function void write_reg(cfg_reg_t r, bit [6:0] v);
      case (r)
        CFG_TABLES:    tables_reg = v[3:0];
        CFG_RANGE:     range_reg = v;
        CFG_RESERVOIR: res_reg = v[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned tables_eff();
      return (tables_reg < 1) ? 1 : (tables_reg > 8) ? 8 : tables_reg;
    endfunction

    function int unsigned range_eff();
      return (range_reg < 1) ? 1 : (range_reg > 64) ? 64 : range_reg;
    endfunction

    function int unsigned res_eff();
      return (res_reg > CAP) ? CAP : res_reg;
    endfunction

    // an insert that lands on a full reservoir reads a random word
    function bit needs_word(in_item_t it);
      int unsigned b;
      if (it.command != CMD_INSERT) return 0;
      if (it.hash_value >= range_eff() || it.table_number >= tables_eff()) return 0;
      b = it.table_number * range_eff() + it.hash_value;
      return res_eff() != 0 && fill[b] == res_eff() && !loaded[total_trials % WORDS];
    endfunction

    function void push(bit [31:0] lab, status_t st, bit [4:0] slot, bit lst, bit eob);
      out_item_t o;
      o.label_out = lab;
      o.status = st;
      o.slot_used = slot;
      o.last = lst;
      o.batch_done = eob;
      pending_results = {pending_results, o};
    endfunction

    function void note(in_item_t it);
      int unsigned b;
      bit [31:0]   t;
      bit [63:0]   n;
      bit [63:0]   r;
      if (it.command == CMD_CLEAR) begin
        foreach (fill[i]) fill[i] = 0;
        push(0, ST_DONE, 0, 1, 0);
        return;
      end
      if (it.command == CMD_LOAD) begin
        words[it.rand_slot] = it.rand_word;
        loaded[it.rand_slot] = 1;
        push(0, ST_DONE, 0, 1, 0);
        return;
      end
      if (it.hash_value >= range_eff() || it.table_number >= tables_eff()) begin
        if (it.command == CMD_INSERT) push(it.label, ST_BAD_ADDR, 0, 1, it.end_of_batch);
        else push(0, ST_BAD_ADDR, 0, 1, 0);
        return;
      end
      b = it.table_number * range_eff() + it.hash_value;
      if (it.command == CMD_QUERY) begin
        if (fill[b] == 0) push(0, ST_QUERY_EMPTY, 0, 1, 0);
        for (int i = 0; i < fill[b]; i++)
          push(store[b][i], ST_QUERY_LABEL, i[4:0], i + 1 == fill[b], 0);
        return;
      end
      if (res_eff() != 0 && fill[b] == res_eff()) begin
        t = total_trials;
        n = trials[b];
        total_trials = t + 1;
        trials[b] = n[31:0] + 1;
        r = {32'd0, words[t % WORDS]} % (n + 1);
        if (r < res_eff()) begin
          store[b][r] = it.label;
          push(it.label, ST_REPLACED, r[4:0], 1, it.end_of_batch);
        end else begin
          push(it.label, ST_SAMPLED_OUT, 0, 1, it.end_of_batch);
        end
        return;
      end
      if (fill[b] >= CAP) begin
        push(it.label, ST_DROPPED, 0, 1, it.end_of_batch);
        return;
      end
      store[b][fill[b]] = it.label;
      push(it.label, ST_APPENDED, fill[b][4:0], 1, it.end_of_batch);
      fill[b] = 6'(fill[b] + 6'd1);
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: label %h status %0d slot %0d last %b batch %b",
                   got.label_out, got.status, got.slot_used, got.last, got.batch_done);
        return;
      end
      want = pending_results.pop_front();
      results_seen++;
      status_seen[got.status]++;
      if (got.label_out !== want.label_out || got.status !== want.status ||
          got.slot_used !== want.slot_used || got.last !== want.last ||
          got.batch_done !== want.batch_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp label %h st %0d slot %0d last %b batch %b, got %h %0d %0d %b %b",
                   want.label_out, want.status, want.slot_used, want.last, want.batch_done,
                   got.label_out, got.status, got.slot_used, got.last, got.batch_done);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic write_enable;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  lbtr_stream_if #(.item_t(in_item_t))  items_ch ();
  lbtr_stream_if #(.item_t(out_item_t)) results_ch ();

  lsh_bucket_table_reservoir i_dut (
    .clk          (clk),
    .rst          (rst),
    .items_in     (items_ch),
    .results_out  (results_ch),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  bucket_scoreboard sb;
  bit   idling_on;
  bit   hold_req;
  int   items_sent;
  int   cycles;

  always #4 clk = ~clk;

  initial begin
    clk = 0;
    rst = 1;
    sb = new();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) sb.check(results_ch.data);
  end

  // receiver with random stalls and one long hold-off
  initial begin
    results_ch.ready <= 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        results_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
        results_ch.ready <= 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        results_ch.ready <= 0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        results_ch.ready <= 1;
      end else begin
        results_ch.ready <= 1;
      end
    end
  end

  task automatic send_item(in_item_t it);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      items_ch.valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    items_ch.valid <= 1;
    items_ch.data <= it;
    do @(posedge clk); while (!items_ch.ready);
    sb.note(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    items_ch.valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t r, bit [6:0] v);
    write_enable <= 1;
    reg_index <= r;
    write_data <= v;
    @(posedge clk);
    write_enable <= 0;
    sb.write_reg(r, v);
  endtask

  function automatic in_item_t make_item(command_t c, bit [2:0] tab, bit [15:0] h);
    in_item_t it;
    it.command = c;
    it.label = $urandom;
    it.hash_value = h;
    it.table_number = tab;
    it.rand_slot = 8'($urandom);
    it.rand_word = $urandom;
    it.end_of_batch = 1'($urandom);
    return it;
  endfunction

  // mostly well-addressed items on a few buckets so they fill and hit the reservoir
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned k;
    int unsigned hmax;
    k = $urandom_range(0, 99);
    hmax = (sb.range_eff() > 3) ? 3 : sb.range_eff() - 1;
    it = make_item(CMD_INSERT, 3'($urandom_range(0, sb.tables_eff() - 1)),
                   16'($urandom_range(0, hmax)));
    if (k < 8) begin
      it.hash_value = 16'($urandom);
      it.table_number = 3'($urandom);
    end else if (k < 12) begin
      it.table_number = 3'($urandom);
    end
    if (k >= 60 && k < 80) it.command = CMD_QUERY;
    else if (k >= 80 && k < 98) it.command = CMD_LOAD;
    else if (k >= 98) it.command = CMD_CLEAR;
    if (sb.needs_word(it)) begin
      it.command = CMD_LOAD;
      it.rand_slot = 8'(sb.total_trials % WORDS);
    end
    return it;
  endfunction

  initial begin
    in_item_t it;
    bit [6:0] phase_cfg [7][3];
    phase_cfg = '{'{7'd1, 7'd1, 7'd4}, '{7'd0, 7'd0, 7'd32}, '{7'd127, 7'd127, 7'd0},
                  '{7'd3, 7'd5, 7'd63}, '{7'd1, 7'd2, 7'd0}, '{7'd8, 7'd64, 7'd1},
                  '{7'd2, 7'd3, 7'd8}};
    items_ch.valid <= 0;
    items_ch.data <= '0;
    write_enable <= 0;
    reg_index <= CFG_TABLES;
    write_data <= 0;
    idling_on = 1;
    hold_req = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, every command, empty and bad-address cases
    it = make_item(CMD_LOAD, 0, 0);
    it.rand_slot = 0;
    it.rand_word = 0;
    send_item(it);
    it.rand_slot = 8'hff;
    it.rand_word = 32'hffffffff;
    send_item(it);
    it = make_item(CMD_QUERY, 7, 63);
    send_item(it);
    it = make_item(CMD_INSERT, 7, 63);
    it.label = 32'hffffffff;
    it.end_of_batch = 1;
    send_item(it);
    it = make_item(CMD_INSERT, 7, 63);
    it.label = 0;
    it.end_of_batch = 0;
    send_item(it);
    it = make_item(CMD_INSERT, 0, 0);
    send_item(it);
    send_item(make_item(CMD_QUERY, 7, 63));
    send_item(make_item(CMD_QUERY, 0, 0));
    send_item(make_item(CMD_INSERT, 0, 16'hffff));
    send_item(make_item(CMD_QUERY, 3, 16'd64));
    send_item(make_item(CMD_CLEAR, 0, 0));
    send_item(make_item(CMD_QUERY, 7, 63));
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      write_cfg(CFG_TABLES, phase_cfg[p][0]);
      write_cfg(CFG_RANGE, phase_cfg[p][1]);
      write_cfg(CFG_RESERVOIR, phase_cfg[p][2]);
      for (int n = 0; n < 72; n++) begin
        if (p == 1 && n == 20) hold_req = 1;
        if (p == 6 && n == 30) idling_on = 0;
        send_item(random_item());
      end
      wait_drained();
    end

    $display("sent %0d items over 7 register settings, checked %0d results", items_sent,
             sb.results_seen);
    $display("status counts: app %0d repl %0d smp %0d drop %0d bad %0d ql %0d qe %0d done %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4], sb.status_seen[5], sb.status_seen[6], sb.status_seen[7]);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
